// ===== hdl/rpi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray and plane intersection package
// Shared widths, constants and transaction structures for the intersection
// pipeline and its divider chain.
// ----------------------------------------------------------------------------
package rpi_pkg;

   // Fixed-point format and field widths.
   localparam int FRAC_BITS = 16;
   localparam int WORD_W    = 32;
   localparam int TAG_W     = 16;
   localparam int EPS_W     = WORD_W - 1;

   // Internal arithmetic widths.
   localparam int PROD_W    = 2 * WORD_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int MAG_W     = PROD_W + 1;
   localparam int NUM_W     = MAG_W + FRAC_BITS;
   localparam int QBITS     = WORD_W - 1;
   localparam int HIGH_W    = NUM_W - QBITS;
   localparam int REM_W     = MAG_W + 1;
   localparam int DIV_CELLS = QBITS;

   // Stream packing.
   localparam int REQ_W     = 10 * WORD_W + TAG_W;
   localparam int RSP_USED  = 1 + 4 * WORD_W + TAG_W;
   localparam int RSP_W     = ((RSP_USED + 7) / 8) * 8;

   // Largest positive ray parameter.
   localparam logic [QBITS-1:0] T_MAX = {QBITS{1'b1}};

   typedef logic signed [WORD_W-1:0] word_type;

   // Ray data that rides along with every transaction.
   typedef struct packed {
      logic signed [WORD_W-1:0] eye_x;
      logic signed [WORD_W-1:0] eye_y;
      logic signed [WORD_W-1:0] eye_z;
      logic signed [WORD_W-1:0] dir_x;
      logic signed [WORD_W-1:0] dir_y;
      logic signed [WORD_W-1:0] dir_z;
      logic [TAG_W-1:0]         tag;
      logic                     live;
   } ray_type;

   // State handed from one divider cell to the next.
   typedef struct packed {
      logic [REM_W-1:0] rem;
      logic [MAG_W-1:0] den;
      logic [QBITS-1:0] nlow;
      logic [QBITS-1:0] quo;
      logic             sat;
      ray_type          ray;
   } div_type;

endpackage

// ===== hdl/rpi_dot.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dot product front end
// Forms the denominator and numerator products, sums them exactly, checks
// the denominator against epsilon and prepares the long division.
// ----------------------------------------------------------------------------
module rpi_dot
   import rpi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ray_type          in_ray,
   input  word_type         normal_x,
   input  word_type         normal_y,
   input  word_type         normal_z,
   input  word_type         plane_d,
   input  logic [EPS_W-1:0] epsilon,
   output logic             out_valid,
   input  logic             out_ready,
   output div_type          out_data
);

   logic                     v1_ff, v2_ff, v3_ff;
   logic                     r1, r2, r3;
   ray_type                  ray1_ff, ray2_ff;
   ray_type                  ray2_in;
   logic signed [PROD_W-1:0] dx_ff, dy_ff, dz_ff, ex_ff, ey_ff, ez_ff;
   word_type                 pd_ff;
   logic [MAG_W-1:0]         den_ff, num_ff;
   div_type                  d3_ff;
   logic signed [SUM_W-1:0]  den_s, num_s, thr_s;
   logic [NUM_W-1:0]         nwide;
   logic [HIGH_W-1:0]        high;
   div_type                  d3_in;

   // Each stage loads when it is empty or its successor takes its transaction.
   assign r3       = !v3_ff || out_ready;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
      end
   end

   // Stage one: the six full products.
   always_ff @(posedge clock) begin
      if (r1) begin
         dx_ff   <= PROD_W'(in_ray.dir_x * normal_x);
         dy_ff   <= PROD_W'(in_ray.dir_y * normal_y);
         dz_ff   <= PROD_W'(in_ray.dir_z * normal_z);
         ex_ff   <= PROD_W'(in_ray.eye_x * normal_x);
         ey_ff   <= PROD_W'(in_ray.eye_y * normal_y);
         ez_ff   <= PROD_W'(in_ray.eye_z * normal_z);
         pd_ff   <= plane_d;
         ray1_ff <= in_ray;
      end
   end

   // Stage two: exact sums and the denominator and sign tests.
   always_comb begin
      den_s = SUM_W'(dx_ff) + SUM_W'(dy_ff) + SUM_W'(dz_ff);
      num_s = -(SUM_W'(ex_ff) + SUM_W'(ey_ff) + SUM_W'(ez_ff)
                + (SUM_W'(pd_ff) <<< FRAC_BITS));
      thr_s = $signed({{(SUM_W - EPS_W - FRAC_BITS){1'b0}}, epsilon,
                       {FRAC_BITS{1'b0}}});
      ray2_in      = ray1_ff;
      ray2_in.live = ray1_ff.live && (den_s > thr_s) && !num_s[SUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (r2) begin
         den_ff  <= den_s[MAG_W-1:0];
         num_ff  <= num_s[MAG_W-1:0];
         ray2_ff <= ray2_in;
      end
   end

   // Stage three: the quotient saturates when its upper part reaches den.
   always_comb begin
      nwide      = {num_ff, {FRAC_BITS{1'b0}}};
      high       = nwide[NUM_W-1:QBITS];
      d3_in.sat  = NUM_W'(high) >= NUM_W'(den_ff);
      d3_in.rem  = REM_W'(high);
      d3_in.den  = den_ff;
      d3_in.nlow = nwide[QBITS-1:0];
      d3_in.quo  = '0;
      d3_in.ray  = ray2_ff;
   end

   always_ff @(posedge clock) begin
      if (r3) d3_ff <= d3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = d3_ff;

endmodule

// ===== hdl/rpi_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step: shifts in the next numerator bit, subtracts
// the denominator when it fits and appends one quotient bit.
// ----------------------------------------------------------------------------
module rpi_div_cell
   import rpi_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_ready,
   output div_type out_data
);

   logic             valid_ff;
   div_type          data_ff, data_in;
   logic [REM_W-1:0] rem_sh, den_w;
   logic             fits;

   assign in_ready = !valid_ff || out_ready;

   // Trial subtraction of the denominator.
   always_comb begin
      rem_sh       = {in_data.rem[REM_W-2:0], in_data.nlow[QBITS-1]};
      den_w        = REM_W'(in_data.den);
      fits         = rem_sh >= den_w;
      data_in      = in_data;
      data_in.rem  = fits ? rem_sh - den_w : rem_sh;
      data_in.nlow = {in_data.nlow[QBITS-2:0], 1'b0};
      data_in.quo  = {in_data.quo[QBITS-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/rpi_point.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intersection point back end
// Finalizes t, applies the epsilon test on t and forms the saturated point
// eye + t * dir; holds the result in the output register.
// ----------------------------------------------------------------------------
module rpi_point
   import rpi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  div_type          in_data,
   input  logic [EPS_W-1:0] epsilon,
   output logic             out_valid,
   input  logic             out_ready,
   output logic             hit,
   output word_type         hit_t,
   output word_type         point_x,
   output word_type         point_y,
   output word_type         point_z,
   output logic [TAG_W-1:0] hit_tag
);

   logic                     v1_ff, v2_ff, r1, r2;
   logic [QBITS-1:0]         t_in, t_ff;
   logic                     hit1_ff, hit2_ff;
   logic signed [PROD_W-1:0] px_ff, py_ff, pz_ff;
   word_type                 ex_ff, ey_ff, ez_ff;
   logic [TAG_W-1:0]         tag1_ff, tag2_ff;
   word_type                 t2_ff, x2_ff, y2_ff, z2_ff;
   word_type                 x_in, y_in, z_in;

   // Clamp a wide signed sum to the 32-bit range.
   function automatic word_type sat_word(input logic signed [MAG_W-1:0] s);
      logic top_zero, top_ones;
      top_zero = s[MAG_W-1:WORD_W-1] == '0;
      top_ones = s[MAG_W-1:WORD_W-1] == '1;
      if (top_zero || top_ones) return s[WORD_W-1:0];
      else if (s[MAG_W-1]) return {1'b1, {(WORD_W-1){1'b0}}};
      else return {1'b0, {(WORD_W-1){1'b1}}};
   endfunction

   assign r2       = !v2_ff || out_ready;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
      end
   end

   // Stage one: saturated t, epsilon test and the three t * dir products.
   assign t_in = in_data.sat ? T_MAX : in_data.quo;

   always_ff @(posedge clock) begin
      if (r1) begin
         t_ff    <= t_in;
         hit1_ff <= in_data.ray.live && (t_in > epsilon);
         px_ff   <= PROD_W'($signed({1'b0, t_in}) * in_data.ray.dir_x);
         py_ff   <= PROD_W'($signed({1'b0, t_in}) * in_data.ray.dir_y);
         pz_ff   <= PROD_W'($signed({1'b0, t_in}) * in_data.ray.dir_z);
         ex_ff   <= in_data.ray.eye_x;
         ey_ff   <= in_data.ray.eye_y;
         ez_ff   <= in_data.ray.eye_z;
         tag1_ff <= in_data.ray.tag;
      end
   end

   // Stage two: floor scaling, add the eye point and saturate.
   always_comb begin
      x_in = sat_word(MAG_W'(ex_ff) + MAG_W'(px_ff >>> FRAC_BITS));
      y_in = sat_word(MAG_W'(ey_ff) + MAG_W'(py_ff >>> FRAC_BITS));
      z_in = sat_word(MAG_W'(ez_ff) + MAG_W'(pz_ff >>> FRAC_BITS));
   end

   always_ff @(posedge clock) begin
      if (r2) begin
         hit2_ff <= hit1_ff;
         t2_ff   <= hit1_ff ? {1'b0, t_ff} : '0;
         x2_ff   <= hit1_ff ? x_in : '0;
         y2_ff   <= hit1_ff ? y_in : '0;
         z2_ff   <= hit1_ff ? z_in : '0;
         tag2_ff <= hit1_ff ? tag1_ff : '0;
      end
   end

   assign out_valid = v2_ff;
   assign hit       = hit2_ff;
   assign hit_t     = t2_ff;
   assign point_x   = x2_ff;
   assign point_y   = y2_ff;
   assign point_z   = z2_ff;
   assign hit_tag   = tag2_ff;

endmodule

// ===== hdl/ray_plane_intersection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray and plane intersection
// Tests one ray against one plane per transaction and returns the hit
// distance, the intersection point and the object tag.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_    | in        | eye xyz, dir xyz, normal xyz, plane_d, object_tag
//  rsp_    | out       | hit, hit_t, point xyz, hit_tag
//  csr_    | in        | epsilon, written when csr_we is high
//
// One transaction enters per cycle unless a stalled result has filled every
// stage. The pipeline holds the product and sum stages, one divider cell per
// quotient bit (31 cells), and the point stages. Reset clears all stage valid
// flags and sets epsilon to 1. A stalled result stops only stages that are
// full; empty stages keep accepting.
// ----------------------------------------------------------------------------
module ray_plane_intersection
   import rpi_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // eye_x, eye_y, eye_z, dir_x, dir_y, dir_z, normal_x, normal_y,
   // normal_z, plane_d, object_tag
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // hit, hit_t, point_x, point_y, point_z, hit_tag, zero padding
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_we,
   input  logic [EPS_W-1:0] csr_wdata
);

   logic [EPS_W-1:0] epsilon_ff;
   ray_type          in_ray;
   logic             link_valid [0:DIV_CELLS];
   logic             link_ready [0:DIV_CELLS];
   div_type          link_data  [0:DIV_CELLS];
   logic             hit;
   word_type         hit_t, point_x, point_y, point_z;
   logic [TAG_W-1:0] hit_tag;

   // Epsilon register.
   always_ff @(posedge clock) begin
      if (reset) begin
         epsilon_ff <= EPS_W'(1);
      end else if (csr_we) begin
         epsilon_ff <= csr_wdata;
      end
   end

   // Unpack the ray fields.
   always_comb begin
      in_ray.eye_x = req_tdata[0*WORD_W +: WORD_W];
      in_ray.eye_y = req_tdata[1*WORD_W +: WORD_W];
      in_ray.eye_z = req_tdata[2*WORD_W +: WORD_W];
      in_ray.dir_x = req_tdata[3*WORD_W +: WORD_W];
      in_ray.dir_y = req_tdata[4*WORD_W +: WORD_W];
      in_ray.dir_z = req_tdata[5*WORD_W +: WORD_W];
      in_ray.tag   = req_tdata[10*WORD_W +: TAG_W];
      in_ray.live  = 1'b1;
   end

   rpi_dot u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_ray    (in_ray),
      .normal_x  (req_tdata[6*WORD_W +: WORD_W]),
      .normal_y  (req_tdata[7*WORD_W +: WORD_W]),
      .normal_z  (req_tdata[8*WORD_W +: WORD_W]),
      .plane_d   (req_tdata[9*WORD_W +: WORD_W]),
      .epsilon   (epsilon_ff),
      .out_valid (link_valid[0]),
      .out_ready (link_ready[0]),
      .out_data  (link_data[0])
   );

   // Divider chain, one quotient bit per cell.
   for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
      rpi_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[i]),
         .in_ready  (link_ready[i]),
         .in_data   (link_data[i]),
         .out_valid (link_valid[i+1]),
         .out_ready (link_ready[i+1]),
         .out_data  (link_data[i+1])
      );
   end

   rpi_point u_point (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (link_valid[DIV_CELLS]),
      .in_ready  (link_ready[DIV_CELLS]),
      .in_data   (link_data[DIV_CELLS]),
      .epsilon   (epsilon_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .hit       (hit),
      .hit_t     (hit_t),
      .point_x   (point_x),
      .point_y   (point_y),
      .point_z   (point_z),
      .hit_tag   (hit_tag)
   );

   assign rsp_tdata = {{(RSP_W - RSP_USED){1'b0}}, hit_tag, point_z, point_y,
                       point_x, hit_t, hit};

`ifndef NO_ASSERTIONS
   // A miss carries all-zero result fields.
   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !hit) |-> (rsp_tdata[RSP_USED-1:1] == '0))
      else $error("miss result has nonzero fields");

   // A hit always has a positive t.
   a_hit_t_pos : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && hit) |-> (!hit_t[WORD_W-1] && (hit_t != '0)))
      else $error("hit with nonpositive t");

   // The input stalls only when the whole pipeline is full and backpressured.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled without output backpressure");
`endif

endmodule

// ===== bench/ray_plane_intersection_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ray and plane intersection testbench
// Drives ray and plane transactions into the intersection pipeline and
// compares every result with a bit-accurate fixed-point predictor. The run
// covers directed corner cases, random rays under several epsilon settings
// and idle patterns, and a long result stall that backs up the pipeline.
// ----------------------------------------------------------------------------
module ray_plane_intersection_tb;
   import rpi_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 40;

   // Request fields, last field in the highest bits.
   typedef struct packed {
      logic [TAG_W-1:0] object_tag;
      word_type         plane_d;
      word_type         normal_z;
      word_type         normal_y;
      word_type         normal_x;
      word_type         dir_z;
      word_type         dir_y;
      word_type         dir_x;
      word_type         eye_z;
      word_type         eye_y;
      word_type         eye_x;
   } ray_plane_type;

   // Result fields, hit flag in bit 0.
   typedef struct packed {
      logic [RSP_W-RSP_USED-1:0] pad;
      logic [TAG_W-1:0]          hit_tag;
      word_type                  point_z;
      word_type                  point_y;
      word_type                  point_x;
      word_type                  hit_t;
      logic                      hit;
   } hit_info_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_we;
   logic [EPS_W-1:0] csr_wdata;

   hit_info_type     pending_hits[$];
   logic [EPS_W-1:0] model_epsilon;
   int               error_count;
   int               send_idle_pct;
   int               recv_idle_pct;
   int               hold_cycles;
   int               quiet_cycles;

   ray_plane_intersection u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Clamp a wide signed value to the 32-bit signed range.
   function automatic word_type clamp_word(longint v);
      if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
      if (v < -64'sh80000000) return 32'sh80000000;
      return word_type'(v);
   endfunction

   // Compute the expected intersection result for one ray and plane.
   function automatic hit_info_type intersect_ray(ray_plane_type r,
                                                  logic [EPS_W-1:0] eps);
      hit_info_type       res;
      logic signed [67:0] den;
      logic signed [67:0] thr;
      logic signed [67:0] num;
      logic [127:0]       quo;
      longint             t;
      res = '0;
      den = 68'(longint'(r.dir_x) * longint'(r.normal_x))
          + 68'(longint'(r.dir_y) * longint'(r.normal_y))
          + 68'(longint'(r.dir_z) * longint'(r.normal_z));
      thr = 68'(longint'(eps)) <<< FRAC_BITS;
      if (den <= thr) return res;
      num = -(68'(longint'(r.normal_x) * longint'(r.eye_x))
            + 68'(longint'(r.normal_y) * longint'(r.eye_y))
            + 68'(longint'(r.normal_z) * longint'(r.eye_z))
            + (68'(longint'(r.plane_d)) <<< FRAC_BITS));
      if (num < 0) return res;
      quo = (128'(num) << FRAC_BITS) / 128'(den);
      t = (quo > 128'h7FFFFFFF) ? 64'sh7FFFFFFF : longint'(quo[31:0]);
      if (t <= longint'(eps)) return res;
      res.hit     = 1'b1;
      res.hit_t   = word_type'(t);
      res.point_x = clamp_word(longint'(r.eye_x) + ((t * longint'(r.dir_x)) >>> FRAC_BITS));
      res.point_y = clamp_word(longint'(r.eye_y) + ((t * longint'(r.dir_y)) >>> FRAC_BITS));
      res.point_z = clamp_word(longint'(r.eye_z) + ((t * longint'(r.dir_z)) >>> FRAC_BITS));
      res.hit_tag = r.object_tag;
      return res;
   endfunction

   // Offer one transaction, idling first at random, and record its result.
   task automatic send_ray(ray_plane_type r);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= r;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_hits.push_back(intersect_ray(r, model_epsilon));
   endtask

   // Drop the request valid after the last transaction of a phase.
   task automatic stop_requests();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Write epsilon once the pipeline has drained.
   task automatic write_epsilon(logic [EPS_W-1:0] value);
      stop_requests();
      wait (pending_hits.size() == 0);
      repeat (DRAIN_WAIT) @(negedge clock);
      csr_we        <= 1'b1;
      csr_wdata     <= value;
      model_epsilon  = value;
      @(negedge clock);
      csr_we        <= 1'b0;
   endtask

   function automatic word_type small_fixed(int range);
      return word_type'($signed($urandom_range(2 * range)) - range);
   endfunction

   function automatic word_type rand_word();
      case ($urandom_range(3))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         default: return word_type'($urandom);
      endcase
   endfunction

   // Random ray: mostly geometry that faces the plane, some noise.
   function automatic ray_plane_type make_ray();
      ray_plane_type r;
      longint        den;
      int            kind;
      kind = $urandom_range(99);
      r.object_tag = TAG_W'($urandom);
      if (kind < 70) begin
         r.eye_x    = small_fixed(1 << 22);
         r.eye_y    = small_fixed(1 << 22);
         r.eye_z    = small_fixed(1 << 22);
         r.dir_x    = small_fixed(1 << 18);
         r.dir_y    = small_fixed(1 << 18);
         r.dir_z    = small_fixed(1 << 18);
         r.normal_x = small_fixed(1 << 16);
         r.normal_y = small_fixed(1 << 16);
         r.normal_z = small_fixed(1 << 16);
         r.plane_d  = small_fixed(1 << 24);
         den = longint'(r.dir_x) * r.normal_x + longint'(r.dir_y) * r.normal_y
             + longint'(r.dir_z) * r.normal_z;
         if (den < 0) begin
            r.dir_x = -r.dir_x;
            r.dir_y = -r.dir_y;
            r.dir_z = -r.dir_z;
         end
      end else if (kind < 85) begin
         r.eye_x    = $urandom;
         r.eye_y    = $urandom;
         r.eye_z    = $urandom;
         r.dir_x    = $urandom;
         r.dir_y    = $urandom;
         r.dir_z    = $urandom;
         r.normal_x = $urandom;
         r.normal_y = $urandom;
         r.normal_z = $urandom;
         r.plane_d  = $urandom;
      end else begin
         r.eye_x    = rand_word();
         r.eye_y    = rand_word();
         r.eye_z    = rand_word();
         r.dir_x    = rand_word();
         r.dir_y    = rand_word();
         r.dir_z    = rand_word();
         r.normal_x = rand_word();
         r.normal_y = rand_word();
         r.normal_z = rand_word();
         r.plane_d  = rand_word();
      end
      return r;
   endfunction

   function automatic ray_plane_type axis_ray(word_type eye_z, word_type dir_z,
                                              word_type normal_z, word_type plane_d);
      ray_plane_type r;
      r = '0;
      r.eye_z      = eye_z;
      r.dir_z      = dir_z;
      r.normal_z   = normal_z;
      r.plane_d    = plane_d;
      r.object_tag = 16'hA5C3;
      return r;
   endfunction

   // Corner cases: simple hit, plane behind, parallel, boundary, saturation.
   task automatic test_directed();
      ray_plane_type r;
      send_ray('0);
      send_ray(axis_ray(0, 32'sh10000, 32'sh10000, -32'sh50000));
      send_ray(axis_ray(0, 32'sh10000, 32'sh10000, 32'sh50000));
      send_ray(axis_ray(0, 32'sh10000, 32'sh10000, 0));
      send_ray(axis_ray(0, 1, 32'sh10000, -32'sh10000));
      send_ray(axis_ray(0, 2, 1, -32'sh10000));
      send_ray(axis_ray(0, 32'sh10000, 1, -1));
      send_ray(axis_ray(0, -32'sh10000, 32'sh10000, -32'sh50000));
      r = '1;
      send_ray(r);
      r = {TAG_W'(16'hFFFF), {10{32'sh7FFFFFFF}}};
      send_ray(r);
      r = {TAG_W'(16'h0000), {10{32'sh80000000}}};
      send_ray(r);
      write_epsilon('0);
      send_ray(axis_ray(0, 2, 1, -32'sh10000));
      send_ray(axis_ray(32'sh7FFF0000, 32'sh7FFFFFFF, 1, -32'sh7FFFFFFF));
      send_ray(axis_ray(32'sh80000000, 32'sh80000001, -1, -32'sh7FFFFFFF));
      send_ray(axis_ray(0, 32'sh10000, 32'sh10000, -1));
      send_ray(axis_ray(0, 32'sh10000, 32'sh10000, 0));
      write_epsilon({EPS_W{1'b1}});
      send_ray(axis_ray(0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, -32'sh7FFFFFFF));
      send_ray(axis_ray(0, 32'sh10000, 32'sh10000, -32'sh50000));
      write_epsilon(EPS_W'(32'h10000));
      send_ray(axis_ray(0, 32'sh10000, 32'sh10000, -32'sh10000));
      send_ray(axis_ray(0, 32'sh10000, 32'sh10000, -32'sh10001));
      send_ray(axis_ray(0, 32'sh10001, 32'sh10000, -32'sh20000));
      stop_requests();
   endtask

   // Random rays under one epsilon value and one idle pattern.
   task automatic test_random(int count, logic [EPS_W-1:0] eps, int send_pct, int recv_pct);
      write_epsilon(eps);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_ray(make_ray());
      stop_requests();
   endtask

   // Hold the result side off while requests keep coming.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles   = 300;
      repeat (120) send_ray(make_ray());
      stop_requests();
   endtask

   // Result side ready, with random idling and an optional long hold-off.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic check_field(string name, longint exp_val, longint act_val);
      if (exp_val != act_val) begin
         $error("%s mismatch: expected %0h, actual %0h", name, exp_val, act_val);
         error_count++;
      end
   endtask

   // Compare every result transaction with the oldest prediction.
   always @(posedge clock) begin
      hit_info_type got;
      hit_info_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_hits.size() == 0) begin
            $error("result transaction with no prediction pending");
            error_count++;
         end else begin
            want = pending_hits.pop_front();
            check_field("hit", want.hit, got.hit);
            check_field("hit_t", want.hit_t, got.hit_t);
            check_field("point_x", want.point_x, got.point_x);
            check_field("point_y", want.point_y, got.point_y);
            check_field("point_z", want.point_z, got.point_z);
            check_field("hit_tag", want.hit_tag, got.hit_tag);
         end
      end
   end

   // End the run if no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Test sequence.
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      rsp_tready    = 1'b0;
      csr_we        = 1'b0;
      csr_wdata     = '0;
      model_epsilon = EPS_W'(1);
      error_count   = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_cycles   = 0;
      quiet_cycles  = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random(400, EPS_W'(1), 16, 69);
      test_random(400, EPS_W'($urandom_range(32'h20000)), 69, 16);
      test_backpressure();
      test_random(280, EPS_W'(0), 0, 0);
      test_random(100, {EPS_W{1'b1}}, 0, 0);

      wait (pending_hits.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== ray_plane_intersection.f =====
hdl/rpi_pkg.sv
hdl/rpi_dot.sv
hdl/rpi_div_cell.sv
hdl/rpi_point.sv
hdl/ray_plane_intersection.sv
bench/ray_plane_intersection_tb.sv
